### sv/obb_pkg.sv
// Shared constants, width helpers and types for the oriented-box overlap test.
`default_nettype none
package obb_pkg;

   localparam int WORD_W          = 48;   // one packed vector field
   localparam int N_FIELDS        = 10;   // vector fields in one request
   localparam int REQ_DATA_W      = WORD_W * N_FIELDS;
   localparam int RSP_DATA_W      = 8;
   localparam int COMPONENT_W_DEF = 16;
   localparam int EPS_W           = 8;
   localparam logic [EPS_W-1:0] EPS_RESET = 8'd1;
   localparam int QUEUE_DEPTH     = 4;
   localparam int FRAC_SHIFT      = 14;   // Q1.14 axis scale
   localparam int ROUND_BIAS      = 8192; // half LSB before the 14-bit shift

   // field slots inside req_tdata
   typedef enum int {
      F_C0 = 0, F_U0 = 1, F_V0 = 2, F_W0 = 3, F_E0 = 4,
      F_C1 = 5, F_U1 = 6, F_V1 = 7, F_W1 = 8, F_E1 = 9
   } field_type;

   // front pipeline occupancy, used for queue credit
   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
   } front_stat_type;

   // rounded local offset (signed integer, same scale as the centers)
   function automatic int tl_w(input int cw);
      return 2 * cw - 10;
   endfunction

   // rounded rotation entry (Q1.14)
   function automatic int r_w(input int cw);
      return 2 * cw - 11;
   endfunction

   // padded absolute rotation entry, unsigned
   function automatic int a_w(input int cw);
      return ((r_w(cw) > EPS_W) ? r_w(cw) : EPS_W) + 1;
   endfunction

   // signed compare width for all 15 tests
   function automatic int cmp_w(input int cw);
      int m;
      m = tl_w(cw) + r_w(cw) + 3;
      if (cw + a_w(cw) + 4 > m) m = cw + a_w(cw) + 4;
      if (cw + 16 > m) m = cw + 16;
      if (tl_w(cw) + 16 > m) m = tl_w(cw) + 16;
      return m + 1;
   endfunction

   function automatic int item_w(input int cw);
      return 3 * tl_w(cw) + 9 * r_w(cw) + 9 * a_w(cw) + 6 * cw;
   endfunction

endpackage
`default_nettype wire

### sv/obb_fifo.sv
// Small register queue between the front and back halves.
`default_nettype none
module obb_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] din,
   input  wire logic              pop,
   output logic      [DATA_W-1:0] dout,
   output logic                   not_empty,
   output logic      [CNT_W-1:0]  count
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule
`default_nettype wire

### sv/obb_front.sv
// Front half: unpacks a box pair, forms local offset and rotation terms.
`default_nettype none
module obb_front #(
   parameter int CW = obb_pkg::COMPONENT_W_DEF,
   localparam int TW = obb_pkg::tl_w(CW),
   localparam int RW = obb_pkg::r_w(CW),
   localparam int AW = obb_pkg::a_w(CW)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic [obb_pkg::REQ_DATA_W-1:0]    in_data,
   input  wire logic [obb_pkg::EPS_W-1:0]         eps,
   output obb_pkg::front_stat_type                stat,
   output logic                                   out_valid,
   output logic [2:0][TW-1:0]                     out_tl,
   output logic [2:0][2:0][RW-1:0]                out_r,
   output logic [2:0][2:0][AW-1:0]                out_a,
   output logic [2:0][CW-1:0]                     out_e0,
   output logic [2:0][CW-1:0]                     out_e1
);
   import obb_pkg::*;

   localparam int XW  = (WORD_W > 3 * CW) ? WORD_W : 3 * CW;
   localparam int DW  = CW + 1;        // center difference
   localparam int PTW = 2 * CW + 1;    // offset * axis
   localparam int PRW = 2 * CW;        // axis * axis
   localparam int STW = 2 * CW + 4;    // offset dot sum with bias
   localparam int SRW = 2 * CW + 3;    // rotation dot sum with bias

   function automatic logic signed [CW-1:0] comp(input logic [WORD_W-1:0] w, input int k);
      logic [XW-1:0] x;
      x = XW'(w);
      return x[k*CW +: CW];
   endfunction

   function automatic logic [WORD_W-1:0] fld(input int f);
      return in_data[f*WORD_W +: WORD_W];
   endfunction

   logic signed [CW-1:0] c0 [3], c1 [3], e0 [3], e1 [3];
   logic signed [CW-1:0] a0 [3][3], a1 [3][3];
   logic signed [DW-1:0] t [3];

   logic signed [PTW-1:0] pt_ff [3][3], pt_in [3][3];
   logic signed [PRW-1:0] pr_ff [3][3][3], pr_in [3][3][3];
   logic [2:0][CW-1:0]    e0_s1_ff, e1_s1_ff, e0_s1_in, e1_s1_in;
   logic                  v1_ff, v2_ff;

   logic [2:0][TW-1:0]      tl_ff, tl_in;
   logic [2:0][2:0][RW-1:0] r_ff, r_in;
   logic [2:0][2:0][AW-1:0] a_ff, a_in;
   logic [2:0][CW-1:0]      e0_s2_ff, e1_s2_ff;

   // stage 1: unpack, center difference, all dot-product partial products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c0[k] = comp(fld(F_C0), k);
         c1[k] = comp(fld(F_C1), k);
         e0[k] = comp(fld(F_E0), k);
         e1[k] = comp(fld(F_E1), k);
         a0[0][k] = comp(fld(F_U0), k);
         a0[1][k] = comp(fld(F_V0), k);
         a0[2][k] = comp(fld(F_W0), k);
         a1[0][k] = comp(fld(F_U1), k);
         a1[1][k] = comp(fld(F_V1), k);
         a1[2][k] = comp(fld(F_W1), k);
         t[k] = DW'(c1[k]) - DW'(c0[k]);
         e0_s1_in[k] = e0[k];
         e1_s1_in[k] = e1[k];
      end
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            pt_in[i][k] = PTW'(t[k]) * PTW'(a0[i][k]);
            for (int j = 0; j < 3; j++) begin
               pr_in[i][j][k] = PRW'(a0[i][k]) * PRW'(a1[j][k]);
            end
         end
      end
   end

   // stage 2: sums, round half up to the target scale, padded magnitude
   always_comb begin
      logic signed [STW-1:0] st;
      logic signed [SRW-1:0] sr;
      logic signed [RW:0]    rm;
      logic signed [RW:0]    rabs;
      for (int i = 0; i < 3; i++) begin
         st = STW'(pt_ff[i][0]) + STW'(pt_ff[i][1]) + STW'(pt_ff[i][2])
            + STW'(ROUND_BIAS);
         tl_in[i] = TW'(st >>> FRAC_SHIFT);
         for (int j = 0; j < 3; j++) begin
            sr = SRW'(pr_ff[i][j][0]) + SRW'(pr_ff[i][j][1]) + SRW'(pr_ff[i][j][2])
               + SRW'(ROUND_BIAS);
            r_in[i][j] = RW'(sr >>> FRAC_SHIFT);
            rm   = (RW+1)'($signed(r_in[i][j]));
            rabs = (rm < 0) ? -rm : rm;
            a_in[i][j] = AW'(rabs[RW-1:0]) + AW'(eps);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff    <= pt_in;
      pr_ff    <= pr_in;
      e0_s1_ff <= e0_s1_in;
      e1_s1_ff <= e1_s1_in;
      tl_ff    <= tl_in;
      r_ff     <= r_in;
      a_ff     <= a_in;
      e0_s2_ff <= e0_s1_ff;
      e1_s2_ff <= e1_s1_ff;
   end

   assign stat.s1_valid = v1_ff;
   assign stat.s2_valid = v2_ff;
   assign out_valid     = v2_ff;
   assign out_tl        = tl_ff;
   assign out_r         = r_ff;
   assign out_a         = a_ff;
   assign out_e0        = e0_s2_ff;
   assign out_e1        = e1_s2_ff;

endmodule
`default_nettype wire

### sv/obb_back.sv
// Back half: projection products, 15 axis tests and the result register.
`default_nettype none
module obb_back #(
   parameter int CW = obb_pkg::COMPONENT_W_DEF,
   localparam int TW = obb_pkg::tl_w(CW),
   localparam int RW = obb_pkg::r_w(CW),
   localparam int AW = obb_pkg::a_w(CW)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_pop,
   input  wire logic [2:0][TW-1:0]            in_tl,
   input  wire logic [2:0][2:0][RW-1:0]       in_r,
   input  wire logic [2:0][2:0][AW-1:0]       in_a,
   input  wire logic [2:0][CW-1:0]            in_e0,
   input  wire logic [2:0][CW-1:0]            in_e1,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic                               out_overlap
);
   import obb_pkg::*;

   localparam int QW  = TW + RW;          // offset * rotation
   localparam int EAW = CW + AW + 1;      // extent * padded rotation
   localparam int CMW = cmp_w(CW);

   function automatic logic signed [CMW-1:0] mag(input logic signed [CMW-1:0] v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int nx(input int i);
      return (i == 2) ? 0 : i + 1;
   endfunction

   function automatic int nx2(input int i);
      return (i == 0) ? 2 : i - 1;
   endfunction

   logic signed [QW-1:0]  qtr_ff [3][3][3], qtr_in [3][3][3];
   logic signed [EAW-1:0] qe0_ff [3][3][3], qe0_in [3][3][3];
   logic signed [EAW-1:0] qe1_ff [3][3][3], qe1_in [3][3][3];
   logic [2:0][TW-1:0]    tl_ff;
   logic [2:0][CW-1:0]    e0_ff, e1_ff;
   logic                  v3_ff;
   logic                  rsp_valid_ff;
   logic                  overlap_ff, overlap_in;
   logic                  advance;

   assign advance = !rsp_valid_ff || out_ready;
   assign in_pop  = in_valid && advance;

   // every cross term of the projections:
   //   qtr[k][m][j] = tl[k]*R[m][j], qe0[m][n][j] = e0[m]*A[n][j],
   //   qe1[m][i][n] = e1[m]*A[i][n]
   always_comb begin
      for (int x = 0; x < 3; x++) begin
         for (int y = 0; y < 3; y++) begin
            for (int z = 0; z < 3; z++) begin
               qtr_in[x][y][z] = QW'($signed(in_tl[x])) * QW'($signed(in_r[y][z]));
               qe0_in[x][y][z] = EAW'($signed(in_e0[x]))
                               * EAW'($signed({1'b0, in_a[y][z]}));
               qe1_in[x][y][z] = EAW'($signed(in_e1[x]))
                               * EAW'($signed({1'b0, in_a[y][z]}));
            end
         end
      end
   end

   // strict separation on any of the 15 axes
   always_comb begin
      logic signed [CMW-1:0] ra, rb, lhs;
      logic                  sep;
      sep = 1'b0;
      for (int i = 0; i < 3; i++) begin
         ra  = CMW'($signed(e0_ff[i])) <<< FRAC_SHIFT;
         rb  = CMW'(qe1_ff[0][i][0]) + CMW'(qe1_ff[1][i][1]) + CMW'(qe1_ff[2][i][2]);
         lhs = mag(CMW'($signed(tl_ff[i]))) <<< FRAC_SHIFT;
         if (lhs > ra + rb) sep = 1'b1;
      end
      for (int j = 0; j < 3; j++) begin
         ra  = CMW'(qe0_ff[0][0][j]) + CMW'(qe0_ff[1][1][j]) + CMW'(qe0_ff[2][2][j]);
         rb  = CMW'($signed(e1_ff[j])) <<< FRAC_SHIFT;
         lhs = mag(CMW'(qtr_ff[0][0][j]) + CMW'(qtr_ff[1][1][j]) + CMW'(qtr_ff[2][2][j]));
         if (lhs > ra + rb) sep = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ra  = CMW'(qe0_ff[nx(i)][nx2(i)][j]) + CMW'(qe0_ff[nx2(i)][nx(i)][j]);
            rb  = CMW'(qe1_ff[nx(j)][i][nx2(j)]) + CMW'(qe1_ff[nx2(j)][i][nx(j)]);
            lhs = mag(CMW'(qtr_ff[nx2(i)][nx(i)][j]) - CMW'(qtr_ff[nx(i)][nx2(i)][j]));
            if (lhs > ra + rb) sep = 1'b1;
         end
      end
      overlap_in = !sep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v3_ff        <= in_pop;
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         qtr_ff     <= qtr_in;
         qe0_ff     <= qe0_in;
         qe1_ff     <= qe1_in;
         tl_ff      <= in_tl;
         e0_ff      <= in_e0;
         e1_ff      <= in_e1;
         overlap_ff <= overlap_in;
      end
   end

   assign out_valid   = rsp_valid_ff;
   assign out_overlap = overlap_ff;

endmodule
`default_nettype wire

### sv/obb_overlap_test.sv
// Top level of the oriented-box overlap test.
`default_nettype none
// Separating-axis overlap test for a pair of oriented boxes. One box pair is a
// req transfer; each produces exactly one rsp transfer whose bit 0 is 1 when no
// separating axis exists (touching counts as overlap) and 0 when separated.
// Throughput is one pair per clock while the response side is ready. From the
// request transfer to the earliest response transfer, with the queue empty
// and the response side ready, a pair passes two front stages (partial
// products, then rounded rotation and local offset), the queue register, one
// back stage of projection products, then the result register. The front runs
// without stalls and takes a request only while the 4-entry queue has room for
// it plus everything still in the front stages; the back drains the queue
// whenever its result register is free or being taken. abs_epsilon is written
// through csr_wr_en / csr_wr_data and must only change while no pair is in
// flight.
module obb_overlap_test #(
   parameter int COMPONENT_WIDTH = obb_pkg::COMPONENT_W_DEF,
   parameter int QUEUE_DEPTH     = obb_pkg::QUEUE_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // req_tdata, low to high, 48 bits each: box0_center, box0_axis_u,
   // box0_axis_v, box0_axis_w, box0_extent, box1_center, box1_axis_u,
   // box1_axis_v, box1_axis_w, box1_extent
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [obb_pkg::REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: bit 0 overlap, bits 7:1 zero
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [obb_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // abs_epsilon write port
   input  wire logic                           csr_wr_en,
   input  wire logic [obb_pkg::EPS_W-1:0]      csr_wr_data
);
   import obb_pkg::*;

   localparam int CW    = COMPONENT_WIDTH;
   localparam int TW    = tl_w(CW);
   localparam int RW    = r_w(CW);
   localparam int AW    = a_w(CW);
   localparam int IW    = item_w(CW);
   localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
   localparam int CRW   = $clog2(QUEUE_DEPTH + 3);

   logic [EPS_W-1:0] eps_ff;

   front_stat_type          fstat;
   logic                    f_valid;
   logic [2:0][TW-1:0]      f_tl, q_tl;
   logic [2:0][2:0][RW-1:0] f_r, q_r;
   logic [2:0][2:0][AW-1:0] f_a, q_a;
   logic [2:0][CW-1:0]      f_e0, f_e1, q_e0, q_e1;
   logic [IW-1:0]           q_din, q_dout;
   logic                    q_not_empty, q_pop;
   logic [QCW-1:0]          q_count;
   logic                    overlap;

   // epsilon register
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   // credit: queued entries plus front stages still to land
   assign req_tready = (CRW'(q_count) + CRW'(fstat.s1_valid) + CRW'(fstat.s2_valid))
                       < CRW'(QUEUE_DEPTH);

   obb_front #(.CW(CW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && req_tready),
      .in_data   (req_tdata),
      .eps       (eps_ff),
      .stat      (fstat),
      .out_valid (f_valid),
      .out_tl    (f_tl),
      .out_r     (f_r),
      .out_a     (f_a),
      .out_e0    (f_e0),
      .out_e1    (f_e1)
   );

   assign q_din = {f_e1, f_e0, f_a, f_r, f_tl};

   obb_fifo #(.DATA_W(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .din       (q_din),
      .pop       (q_pop),
      .dout      (q_dout),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   assign {q_e1, q_e0, q_a, q_r, q_tl} = q_dout;

   obb_back #(.CW(CW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_not_empty),
      .in_pop      (q_pop),
      .in_tl       (q_tl),
      .in_r        (q_r),
      .in_a        (q_a),
      .in_e0       (q_e0),
      .in_e1       (q_e1),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_overlap (overlap)
   );

   assign rsp_tdata = {(RSP_DATA_W-1)'(0), overlap};

endmodule
`default_nettype wire

### sv/obb_checker.sv
// Port-level checker for the oriented-box overlap test, bound to the top level.
`default_nettype none
module obb_checker #(
   parameter int DEPTH = obb_pkg::QUEUE_DEPTH
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [obb_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import obb_pkg::*;

   localparam int MAX_OUT = DEPTH + 4;
   localparam int OW      = $clog2(MAX_OUT + 2);

   logic [OW-1:0] outstanding_ff;
   logic          req_xfer, rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else if (req_xfer && !rsp_xfer) begin
         outstanding_ff <= outstanding_ff + OW'(1);
      end else if (rsp_xfer && !req_xfer) begin
         outstanding_ff <= outstanding_ff - OW'(1);
      end
   end

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> outstanding_ff != '0)
      else $error("response without a pending request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= OW'(MAX_OUT))
      else $error("more requests in flight than the pipeline holds");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:1] == '0)
      else $error("response padding bits set");

endmodule

bind obb_overlap_test obb_checker #(.DEPTH(QUEUE_DEPTH)) u_obb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

### sim/testbench.sv
// Testbench for the oriented-box overlap test: directed and random box pairs.
`default_nettype none
module testbench;
   import obb_pkg::*;

   localparam int CW = 16;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [EPS_W-1:0]      csr_wr_data = '0;

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   obb_overlap_test dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // predictor copy of the epsilon register
   logic [EPS_W-1:0] pad_eps = EPS_RESET;
   // expected rsp_tdata for every pair sent and not yet answered
   logic [RSP_DATA_W-1:0] overlap_q[$];
   int errors = 0;
   int pairs_sent = 0;
   int answers_seen = 0;
   int overlaps_seen = 0;
   int rsp_hold = 0;
   bit rsp_random = 1'b1;

   task automatic report(input string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   // signed component k of a packed vector
   function automatic longint comp(input logic [WORD_W-1:0] w, input int k);
      logic signed [CW-1:0] c;
      c = w[k*CW +: CW];
      return longint'(c);
   endfunction

   // floor((v + 2^13) / 2^14)
   function automatic longint rnd14(input longint v);
      return (v + 8192) >>> 14;
   endfunction

   function automatic longint mag(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // full separating-axis test, returns the overlap bit
   function automatic logic boxes_overlap(input logic [REQ_DATA_W-1:0] d,
                                          input logic [EPS_W-1:0] eps);
      longint c0[3], c1[3], e0[3], e1[3], a0[3][3], a1[3][3];
      longint t[3], tl[3], r[3][3], aa[3][3];
      longint ra, rb, lhs;
      int i1, i2, j1, j2;
      logic sep;
      sep = 1'b0;
      for (int k = 0; k < 3; k++) begin
         c0[k] = comp(d[F_C0*WORD_W +: WORD_W], k);
         e0[k] = comp(d[F_E0*WORD_W +: WORD_W], k);
         c1[k] = comp(d[F_C1*WORD_W +: WORD_W], k);
         e1[k] = comp(d[F_E1*WORD_W +: WORD_W], k);
         for (int i = 0; i < 3; i++) begin
            a0[i][k] = comp(d[(F_U0+i)*WORD_W +: WORD_W], k);
            a1[i][k] = comp(d[(F_U1+i)*WORD_W +: WORD_W], k);
         end
         t[k] = c1[k] - c0[k];
      end
      for (int i = 0; i < 3; i++) begin
         tl[i] = rnd14(t[0]*a0[i][0] + t[1]*a0[i][1] + t[2]*a0[i][2]);
         for (int j = 0; j < 3; j++) begin
            r[i][j] = rnd14(a0[i][0]*a1[j][0] + a0[i][1]*a1[j][1] + a0[i][2]*a1[j][2]);
            aa[i][j] = mag(r[i][j]) + longint'(eps);
         end
      end
      for (int i = 0; i < 3; i++) begin
         ra = e0[i] * 16384;
         rb = e1[0]*aa[i][0] + e1[1]*aa[i][1] + e1[2]*aa[i][2];
         if (mag(tl[i]) * 16384 > ra + rb) sep = 1'b1;
      end
      for (int j = 0; j < 3; j++) begin
         ra = e0[0]*aa[0][j] + e0[1]*aa[1][j] + e0[2]*aa[2][j];
         rb = e1[j] * 16384;
         lhs = mag(tl[0]*r[0][j] + tl[1]*r[1][j] + tl[2]*r[2][j]);
         if (lhs > ra + rb) sep = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
         i1 = (i + 1) % 3;
         i2 = (i + 2) % 3;
         for (int j = 0; j < 3; j++) begin
            j1 = (j + 1) % 3;
            j2 = (j + 2) % 3;
            ra = e0[i1]*aa[i2][j] + e0[i2]*aa[i1][j];
            rb = e1[j1]*aa[i][j2] + e1[j2]*aa[i][j1];
            lhs = mag(tl[i2]*r[i1][j] - tl[i1]*r[i2][j]);
            if (lhs > ra + rb) sep = 1'b1;
         end
      end
      return ~sep;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // one pair transfer; prediction is made at acceptance
   // tvalid stays up after the transfer so the next pair can follow directly
   task automatic send_pair(input logic [REQ_DATA_W-1:0] d, input bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      overlap_q.push_back({7'b0, boxes_overlap(d, pad_eps)});
      pairs_sent++;
      @(negedge clock);
   endtask

   // response side: random stalls, now and then a long one
   always @(negedge clock) begin
      if (!rsp_random) rsp_tready <= 1'b1;
      else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 63) == 0) begin
         rsp_hold = $urandom_range(8, 40);
         rsp_tready <= 1'b0;
      end
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         answers_seen++;
         if (overlap_q.size() == 0)
            report($sformatf("unexpected response %h", rsp_tdata));
         else begin
            if (rsp_tdata !== overlap_q[0])
               report($sformatf("response %0d: got %h want %h",
                                answers_seen, rsp_tdata, overlap_q[0]));
            overlaps_seen += overlap_q[0][0];
            void'(overlap_q.pop_front());
         end
      end
   end

   task automatic drain();
      req_tvalid <= 1'b0;
      while (overlap_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // change epsilon with the block idle
   task automatic set_eps(input logic [EPS_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      pad_eps = v;
   endtask

   function automatic logic [WORD_W-1:0] vec(input int x, input int y, input int z);
      return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
   endfunction

   // axis-aligned pair: offset dx along x, every extent component ex
   function automatic logic [REQ_DATA_W-1:0] aligned_pair(input int dx, input int ex);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[F_U0*WORD_W +: WORD_W] = vec(16384, 0, 0);
      d[F_V0*WORD_W +: WORD_W] = vec(0, 16384, 0);
      d[F_W0*WORD_W +: WORD_W] = vec(0, 0, 16384);
      d[F_U1*WORD_W +: WORD_W] = vec(16384, 0, 0);
      d[F_V1*WORD_W +: WORD_W] = vec(0, 16384, 0);
      d[F_W1*WORD_W +: WORD_W] = vec(0, 0, 16384);
      d[F_E0*WORD_W +: WORD_W] = vec(ex, ex, ex);
      d[F_E1*WORD_W +: WORD_W] = vec(ex, ex, ex);
      d[F_C1*WORD_W +: WORD_W] = vec(dx, 0, 0);
      return d;
   endfunction

   // random axes with components in [-1, 1) in Q1.14, centers close enough to matter
   function automatic logic [REQ_DATA_W-1:0] plausible_pair();
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      for (int f = 0; f < N_FIELDS; f++) begin
         case (f)
            F_C0, F_C1:
               d[f*WORD_W +: WORD_W] = vec($urandom_range(0, 2047) - 1024,
                  $urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024);
            F_E0, F_E1:
               d[f*WORD_W +: WORD_W] = vec($urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023));
            default:
               d[f*WORD_W +: WORD_W] = vec($urandom_range(0, 32767) - 16384,
                  $urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384);
         endcase
      end
      return d;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] noise_pair();
      logic [REQ_DATA_W-1:0] d;
      for (int k = 0; k < REQ_DATA_W / 32; k++) d[k*32 +: 32] = $urandom();
      return d;
   endfunction

   // touching, separated, overlapping, extremes and odd inputs
   task automatic test_directed();
      logic [REQ_DATA_W-1:0] d;
      send_pair('0, 1'b0);
      send_pair('1, 1'b0);
      send_pair(aligned_pair(512, 256), 1'b0);   // faces touch exactly
      send_pair(aligned_pair(513, 256), 1'b0);   // one LSB apart
      send_pair(aligned_pair(-513, 256), 1'b0);
      send_pair(aligned_pair(100, 256), 1'b0);
      send_pair(aligned_pair(0, -256), 1'b0);    // negative extents
      d = aligned_pair(0, 256);
      d[F_C0*WORD_W +: WORD_W] = vec(32767, -32768, 32767);
      d[F_C1*WORD_W +: WORD_W] = vec(-32768, 32767, -32768);
      send_pair(d, 1'b0);
      d = aligned_pair(300, 32767);
      d[F_U0*WORD_W +: WORD_W] = vec(-32768, -32768, -32768);  // non-unit axis
      d[F_V1*WORD_W +: WORD_W] = vec(32767, 32767, 32767);
      send_pair(d, 1'b0);
      d = aligned_pair(700, 256);
      d[F_U1*WORD_W +: WORD_W] = vec(11585, 11585, 0);   // rotated 45 deg
      d[F_V1*WORD_W +: WORD_W] = vec(-11585, 11585, 0);
      send_pair(d, 1'b0);
      d = aligned_pair(20, 64);
      d[F_V0*WORD_W +: WORD_W] = vec(16384, 0, 0);        // degenerate frame
      send_pair(d, 1'b0);
      for (int k = 0; k < 6; k++) send_pair(noise_pair(), 1'b0);
   endtask

   task automatic test_random(input int n);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0, 1:    send_pair(noise_pair(), 1'b1);
            2, 3:    send_pair(aligned_pair($urandom_range(0, 1200) - 600,
                                            $urandom_range(0, 400)), 1'b1);
            default: send_pair(plausible_pair(), 1'b1);
         endcase
         if (k == n / 2) drain();   // sender holds until all answers are in
      end
   endtask

   task automatic test_epsilon_sweep();
      set_eps(8'd0);
      test_directed();
      test_random(350);
      set_eps(8'd255);
      test_directed();
      test_random(350);
      set_eps(8'($urandom_range(2, 254)));
      test_random(350);
      set_eps(8'd1);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300);
      test_epsilon_sweep();
      rsp_random = 1'b0;
      test_random(200);   // receiver always ready, random request gaps
      drain();
      $display("covered %0d box pairs, %0d overlapping, epsilon 0/1/255/random",
               pairs_sent, overlaps_seen);
      if (errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #4000000;
      $display("testbench: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
